### design/assert_macros.svh
// shared assertion helpers for the extended gcd block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define CHK_IMPLY(lbl, c, r, pre, post) \
  lbl: assert property (@(posedge c) disable iff (r) (pre) |-> (post)) \
    else $error("%m: implication check failed");

// next-cycle implication, held off during reset
`define CHK_NEXT(lbl, c, r, pre, post) \
  lbl: assert property (@(posedge c) disable iff (r) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

### design/egcd_pkg.sv
`default_nettype none

package egcd_pkg;

  // default operand width
  localparam int unsigned OPERAND_WIDTH = 32;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_MZERO = 2'd2;

  // request modes; the spare code is handled as plain extended gcd
  localparam logic [1:0] MODE_GCD   = 2'd0;
  localparam logic [1:0] MODE_INV   = 2'd1;
  localparam logic [1:0] MODE_LIN   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // commands from controller to datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ALIGN,
    CMD_DESC,
    CMD_DIV_XM,
    CMD_DIV_BG,
    CMD_TAKE_INV,
    CMD_TAKE_BG,
    CMD_TAKE_MG,
    CMD_TAKE_XN,
    CMD_MUL,
    CMD_FIN_MUL,
    CMD_FIN_ZERO,
    CMD_FIN_NOSOL,
    CMD_FIN_MZERO,
    CMD_OUT
  } cmd_t;

  // datapath status back to controller
  typedef struct packed {
    logic r1_zero;
    logic align_ok;
    logic k_zero;
    logic div_done;
    logic g_one;
    logic m_zero;
    logic rem_zero;
    logic qm_zero;
    logic mode_inv;
    logic mode_lin;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### design/egcd_div.sv
`default_nettype none

module egcd_div #(
  parameter int unsigned OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [OPERAND_WIDTH:0]     dividend,
  input  wire logic [OPERAND_WIDTH-1:0]   divisor,
  output logic      [OPERAND_WIDTH-1:0]   quotient,
  output logic      [OPERAND_WIDTH-1:0]   remainder,
  output logic                            done
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W:0]    dvd;
  logic [W:0]    quo;
  logic [W:0]    rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    rem_sh;
  logic          ge;

  // one restoring step: bring in next dividend bit, trial subtract
  assign rem_sh = {rem[W-1:0], dvd[W]};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CW'(W)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // shift registers of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
      quo <= {quo[W-1:0], ge};
      dvd <= {dvd[W-1:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient  = quo[W-1:0];
  assign remainder = rem[W-1:0];

endmodule

`default_nettype wire

### design/egcd_dp.sv
`default_nettype none

module egcd_dp #(
  parameter int unsigned OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire egcd_pkg::cmd_t                    cmd,
  output egcd_pkg::dp_status_t                   dp_status,
  input  wire logic [1:0]                        req_type,
  input  wire logic [OPERAND_WIDTH-1:0]          operand_a,
  input  wire logic [OPERAND_WIDTH-1:0]          operand_b,
  input  wire logic [OPERAND_WIDTH-1:0]          modulus,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [OPERAND_WIDTH-1:0]               gcd_value,
  output logic signed [OPERAND_WIDTH+1:0]        coef_x,
  output logic signed [OPERAND_WIDTH+1:0]        coef_y,
  output logic [OPERAND_WIDTH-1:0]               answer,
  output logic [1:0]                             status
);

  import egcd_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned C  = W + 2;
  localparam int unsigned KW = $clog2(W);

  // request registers
  logic [1:0]   mode_r;
  logic [W-1:0] b_r;
  logic [W-1:0] m_r;

  // euclid state
  logic [W-1:0]          r0, r1;
  logic [W:0]            d;
  logic [KW-1:0]         k;
  logic signed [C-1:0]   s0, s1, t0, t1;

  // post-processing registers
  logic [W-1:0] bq, nmod, pm, acc, qm;
  logic [W-1:0] ans_r;
  logic [1:0]   st_r;

  // euclid step logic
  logic                align_ok, sub_ok;
  logic [W-1:0]        r_new;
  logic signed [C-1:0] ds, dt, s_new, t_new;

  assign align_ok = {d[W-1:0], 1'b0} <= {1'b0, r0};
  assign sub_ok   = d <= {1'b0, r0};
  assign r_new    = sub_ok ? (r0 - d[W-1:0]) : r0;
  assign ds       = s1 <<< k;
  assign dt       = t1 <<< k;
  assign s_new    = sub_ok ? (s0 - ds) : s0;
  assign t_new    = sub_ok ? (t0 - dt) : t0;

  // magnitude of x for reduction
  logic [C-1:0] s0_u, x_abs;
  assign s0_u  = s0;
  assign x_abs = s0[C-1] ? (~s0_u + 1'b1) : s0_u;

  // shared divider
  logic         div_start, div_done;
  logic [W:0]   div_dvd;
  logic [W-1:0] div_dsr, div_quo, div_rem;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = x_abs[W:0];
    div_dsr   = m_r;
    case (cmd)
      CMD_DIV_XM: begin
        div_start = 1'b1;
      end
      CMD_DIV_BG: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, b_r};
        div_dsr   = r0;
      end
      CMD_TAKE_BG: begin
        div_start = 1'b1;
        div_dvd   = {1'b0, m_r};
        div_dsr   = r0;
      end
      CMD_TAKE_MG: begin
        div_start = 1'b1;
        div_dsr   = div_quo;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  egcd_div #(.OPERAND_WIDTH(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // signed reduction of x into [0, n)
  logic [W-1:0] smod_n, smod_res;
  assign smod_n   = (cmd == CMD_TAKE_XN) ? nmod : m_r;
  assign smod_res = (s0[C-1] && div_rem != '0) ? (smod_n - div_rem) : div_rem;

  // modular add and double for the multiply
  logic [W:0] sum_acc, sum_dbl;
  logic [W:0] n_ext;
  assign n_ext   = {1'b0, nmod};
  assign sum_acc = {1'b0, acc} + {1'b0, pm};
  assign sum_dbl = {1'b0, pm} + {1'b0, pm};

  logic [W:0] acc_red, dbl_red;
  assign acc_red = (sum_acc >= n_ext) ? (sum_acc - n_ext) : sum_acc;
  assign dbl_red = (sum_dbl >= n_ext) ? (sum_dbl - n_ext) : sum_dbl;

  // working registers, steered by the controller
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        mode_r <= req_type;
        b_r    <= operand_b;
        m_r    <= modulus;
        r0     <= operand_a;
        if (req_type == MODE_INV || req_type == MODE_LIN) begin
          r1 <= modulus;
          d  <= {1'b0, modulus};
        end else begin
          r1 <= operand_b;
          d  <= {1'b0, operand_b};
        end
        k  <= '0;
        s0 <= C'(1);
        s1 <= '0;
        t0 <= '0;
        t1 <= C'(1);
      end
      CMD_ALIGN: begin
        d <= {d[W-1:0], 1'b0};
        k <= k + 1'b1;
      end
      CMD_DESC: begin
        if (k != '0) begin
          r0 <= r_new;
          s0 <= s_new;
          t0 <= t_new;
          d  <= d >> 1;
          k  <= k - 1'b1;
        end else begin
          r0 <= r1;
          r1 <= r_new;
          s0 <= s1;
          s1 <= s_new;
          t0 <= t1;
          t1 <= t_new;
          d  <= {1'b0, r_new};
        end
      end
      CMD_TAKE_INV: begin
        ans_r <= smod_res;
        st_r  <= ST_OK;
      end
      CMD_TAKE_BG: begin
        bq <= div_quo;
      end
      CMD_TAKE_MG: begin
        nmod <= div_quo;
      end
      CMD_TAKE_XN: begin
        pm  <= smod_res;
        acc <= '0;
        qm  <= bq;
      end
      CMD_MUL: begin
        if (qm[0]) begin
          acc <= acc_red[W-1:0];
        end
        pm <= dbl_red[W-1:0];
        qm <= qm >> 1;
      end
      CMD_FIN_MUL: begin
        ans_r <= acc;
        st_r  <= ST_OK;
      end
      CMD_FIN_ZERO: begin
        ans_r <= '0;
        st_r  <= ST_OK;
      end
      CMD_FIN_NOSOL: begin
        ans_r <= '0;
        st_r  <= ST_NOSOL;
      end
      CMD_FIN_MZERO: begin
        ans_r <= '0;
        st_r  <= ST_MZERO;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT) begin
      gcd_value <= r0;
      coef_x    <= s0;
      coef_y    <= t0;
      answer    <= ans_r;
      status    <= st_r;
    end
  end

  // status to controller
  always_comb begin
    dp_status.r1_zero  = r1 == '0;
    dp_status.align_ok = align_ok;
    dp_status.k_zero   = k == '0;
    dp_status.div_done = div_done;
    dp_status.g_one    = r0 == W'(1);
    dp_status.m_zero   = m_r == '0;
    dp_status.rem_zero = div_rem == '0;
    dp_status.qm_zero  = qm == '0;
    dp_status.mode_inv = mode_r == MODE_INV;
    dp_status.mode_lin = mode_r == MODE_LIN;
    dp_status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

### design/egcd_ctrl.sv
`default_nettype none

module egcd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire egcd_pkg::dp_status_t dp_status,
  output egcd_pkg::cmd_t            cmd
);

  import egcd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_ALIGN = 11'b000_0000_0100,
    S_DESC  = 11'b000_0000_1000,
    S_POST  = 11'b000_0001_0000,
    S_INV_W = 11'b000_0010_0000,
    S_BG_W  = 11'b000_0100_0000,
    S_MG_W  = 11'b000_1000_0000,
    S_XN_W  = 11'b001_0000_0000,
    S_MUL   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_CHECK;
        end
      end
      // euclid loop: stop once the remainder is zero
      S_CHECK: begin
        state_next = dp_status.r1_zero ? S_POST : S_ALIGN;
      end
      S_ALIGN: begin
        if (dp_status.align_ok) begin
          cmd = CMD_ALIGN;
        end else begin
          state_next = S_DESC;
        end
      end
      S_DESC: begin
        cmd = CMD_DESC;
        if (dp_status.k_zero) begin
          state_next = S_CHECK;
        end
      end
      // pick the follow-up work by mode
      S_POST: begin
        state_next = S_DONE;
        if (!dp_status.mode_inv && !dp_status.mode_lin) begin
          cmd = CMD_FIN_ZERO;
        end else if (dp_status.m_zero) begin
          cmd = CMD_FIN_MZERO;
        end else if (dp_status.mode_inv) begin
          if (!dp_status.g_one) begin
            cmd = CMD_FIN_NOSOL;
          end else begin
            cmd        = CMD_DIV_XM;
            state_next = S_INV_W;
          end
        end else begin
          cmd        = CMD_DIV_BG;
          state_next = S_BG_W;
        end
      end
      S_INV_W: begin
        if (dp_status.div_done) begin
          cmd        = CMD_TAKE_INV;
          state_next = S_DONE;
        end
      end
      S_BG_W: begin
        if (dp_status.div_done) begin
          if (!dp_status.rem_zero) begin
            cmd        = CMD_FIN_NOSOL;
            state_next = S_DONE;
          end else begin
            cmd        = CMD_TAKE_BG;
            state_next = S_MG_W;
          end
        end
      end
      S_MG_W: begin
        if (dp_status.div_done) begin
          cmd        = CMD_TAKE_MG;
          state_next = S_XN_W;
        end
      end
      S_XN_W: begin
        if (dp_status.div_done) begin
          cmd        = CMD_TAKE_XN;
          state_next = S_MUL;
        end
      end
      // shift-and-add modular multiply
      S_MUL: begin
        if (dp_status.qm_zero) begin
          cmd        = CMD_FIN_MUL;
          state_next = S_DONE;
        end else begin
          cmd = CMD_MUL;
        end
      end
      S_DONE: begin
        if (dp_status.out_free) begin
          cmd        = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/extended_gcd_modular_inverse_top.sv
// Extended gcd / modular inverse / linear congruence unit.
// Input channel (in_valid/in_ready) takes one request beat: req_type, operand_a,
// operand_b and modulus. Output channel (out_valid/out_ready) returns one beat
// per request: gcd_value, coef_x, coef_y, answer and status.
// One request is worked on at a time. The Euclid loop runs on a shift-subtract
// datapath. The inverse adds one pass of the serial divider; the congruence
// adds three divider passes and up to OPERAND_WIDTH modular multiply steps.
// in_ready is high only while the unit is idle; a finished result sits in the
// output register, so the next request is taken while the receiver stalls,
// and that request holds in its final state until the output register frees.
// Synchronous reset returns the controller to idle and drops out_valid.
`default_nettype none

`include "assert_macros.svh"

module extended_gcd_modular_inverse_top #(
  parameter int unsigned OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [OPERAND_WIDTH-1:0]      operand_a,
  input  wire logic [OPERAND_WIDTH-1:0]      operand_b,
  input  wire logic [OPERAND_WIDTH-1:0]      modulus,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [OPERAND_WIDTH-1:0]           gcd_value,
  output logic signed [OPERAND_WIDTH+1:0]    coef_x,
  output logic signed [OPERAND_WIDTH+1:0]    coef_y,
  output logic [OPERAND_WIDTH-1:0]           answer,
  output logic [1:0]                         status
);

  import egcd_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  // sequencer
  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  // arithmetic and result registers
  egcd_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .dp_status (dp_status),
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .modulus   (modulus),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gcd_value (gcd_value),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .answer    (answer),
    .status    (status)
  );

  // checks
  `CHK_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready)
  `CHK_IMPLY(a_status_code, clk, rst, out_valid,
             status == ST_OK || status == ST_NOSOL || status == ST_MZERO)
  `CHK_IMPLY(a_answer_zero, clk, rst, out_valid && status != ST_OK, answer == '0)
  `CHK_IMPLY(a_mzero_coef, clk, rst, out_valid && status == ST_MZERO,
             coef_x == 1 && coef_y == 0)

endmodule

`default_nettype wire

### verif/extended_gcd_modular_inverse_top_tb.sv
`default_nettype none

module extended_gcd_modular_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import egcd_pkg::*;

  localparam int W = 32;
  localparam int CW = W + 2;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]   mode;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] m;
  } request_t;

  typedef struct packed {
    logic [W-1:0]  g;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [W-1:0]  ans;
    logic [1:0]    st;
  } egcd_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic [W-1:0] modulus = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] gcd_value;
  logic signed [CW-1:0] coef_x;
  logic signed [CW-1:0] coef_y;
  logic [W-1:0] answer;
  logic [1:0] status;

  request_t     pending_reqs[$];
  egcd_result_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int recv_holdoff = 0;
  bit no_idling = 1'b0;
  bit send_pause = 1'b0;
  bit stim_done = 1'b0;

  extended_gcd_modular_inverse_top #(.OPERAND_WIDTH(W)) u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
    .modulus(modulus), .out_valid(out_valid), .out_ready(out_ready),
    .gcd_value(gcd_value), .coef_x(coef_x), .coef_y(coef_y),
    .answer(answer), .status(status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // extended euclid, returning gcd and signed coefficients
  function automatic logic [W-1:0] euclid(input logic [W-1:0] p, input logic [W-1:0] q,
                                          output longint xo, output longint yo);
    longint unsigned r0, r1, qq, rn;
    longint s0, s1, t0, t1, sn, tn;
    r0 = 64'(p); r1 = 64'(q); s0 = 1; s1 = 0; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      qq = r0 / r1;
      rn = r0 - qq * r1;
      sn = s0 - longint'(qq) * s1;
      tn = t0 - longint'(qq) * t1;
      r0 = r1; r1 = rn;
      s0 = s1; s1 = sn;
      t0 = t1; t1 = tn;
    end
    xo = s0;
    yo = t0;
    return r0[W-1:0];
  endfunction

  // signed value reduced into [0, n)
  function automatic longint unsigned reduce_signed(input longint v, input longint unsigned n);
    longint unsigned r;
    if (v >= 0) return longint'(v) % n;
    r = longint'(-v) % n;
    return (r == 0) ? 0 : n - r;
  endfunction

  // expected outcome of one request
  function automatic egcd_result_t solve_request(input request_t r);
    egcd_result_t e;
    longint x, y;
    longint unsigned g, mr, prod;
    e.ans = '0;
    e.st = ST_OK;
    if (r.mode == MODE_INV || r.mode == MODE_LIN) begin
      g = 64'(euclid(r.a, r.m, x, y));
      if (r.m == 0) e.st = ST_MZERO;
      else if (r.mode == MODE_INV) begin
        if (g != 1) e.st = ST_NOSOL;
        else e.ans = W'(reduce_signed(x, 64'(r.m)));
      end else if ((64'(r.b) % g) != 0) e.st = ST_NOSOL;
      else begin
        mr = 64'(r.m) / g;
        // operands below 2^32, so the 64-bit product cannot wrap
        prod = (reduce_signed(x, mr) * ((64'(r.b) / g) % mr)) % mr;
        e.ans = W'(prod);
      end
    end else begin
      g = 64'(euclid(r.a, r.b, x, y));
    end
    e.g = W'(g);
    e.x = CW'(x);
    e.y = CW'(y);
    return e;
  endfunction

  function automatic request_t make_req(input logic [1:0] md, input logic [W-1:0] a,
                                        input logic [W-1:0] b, input logic [W-1:0] m);
    request_t r;
    r.mode = md; r.a = a; r.b = b; r.m = m;
    return r;
  endfunction

  // operand with varied magnitude so small and full-width values both show up
  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return $urandom_range(0, 1000);
      2: return $urandom & 32'h000f_ffff;
      3: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h8000_0000} - $urandom_range(0, 5);
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    logic [W-1:0] g;
    r.mode = ($urandom_range(0, 19) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
    r.a = rand_operand();
    r.b = rand_operand();
    r.m = ($urandom_range(0, 29) == 0) ? '0 : rand_operand();
    // congruence with a common factor now and then, so it is often solvable
    if (r.mode == MODE_LIN && $urandom_range(0, 1)) begin
      g = $urandom_range(1, 64);
      r.a = g * ($urandom & 32'h00ff_ffff);
      r.m = g * ($urandom_range(1, 32'h00ff_ffff));
      r.b = g * ($urandom & 32'h03ff_ffff);
    end
    return r;
  endfunction

  // stimulus
  initial begin
    pending_reqs.push_back(make_req(MODE_GCD, '0, '0, '0));
    pending_reqs.push_back(make_req(MODE_GCD, '1, '1, '1));
    pending_reqs.push_back(make_req(MODE_GCD, '1, 32'd1, '0));
    pending_reqs.push_back(make_req(MODE_GCD, 32'd240, 32'd46, '0));
    pending_reqs.push_back(make_req(MODE_GCD, '0, 32'd17, '0));
    pending_reqs.push_back(make_req(MODE_SPARE, 32'd99, 32'd78, '1));
    pending_reqs.push_back(make_req(MODE_GCD, 32'hffff_fffe, 32'hffff_ffff, '0));
    pending_reqs.push_back(make_req(MODE_INV, 32'd3, '0, 32'd11));
    pending_reqs.push_back(make_req(MODE_INV, 32'd6, '1, 32'd9));
    pending_reqs.push_back(make_req(MODE_INV, 32'd5, '0, '0));
    pending_reqs.push_back(make_req(MODE_INV, 32'd7, '0, 32'd1));
    pending_reqs.push_back(make_req(MODE_INV, '1, '0, 32'hffff_fffb));
    pending_reqs.push_back(make_req(MODE_INV, '0, '0, 32'd1));
    pending_reqs.push_back(make_req(MODE_LIN, 32'd14, 32'd30, 32'd100));
    pending_reqs.push_back(make_req(MODE_LIN, 32'd14, 32'd31, 32'd100));
    pending_reqs.push_back(make_req(MODE_LIN, 32'd4, 32'd2, '0));
    pending_reqs.push_back(make_req(MODE_LIN, '1, '1, 32'hffff_fffe));
    pending_reqs.push_back(make_req(MODE_LIN, 32'h8000_0001, 32'hffff_ffff, 32'hffff_fffd));
    pending_reqs.push_back(make_req(MODE_LIN, '0, '0, 32'd12));
    pending_reqs.push_back(make_req(MODE_LIN, '0, 32'd5, 32'd12));
    repeat (1850) pending_reqs.push_back(rand_request());
  end

  // reset and run control
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // receiver holds off long while the sender keeps offering
    @(posedge clk);
    recv_holdoff <= 3000;
    wait (pending_reqs.size() < 1400);
    // sender pauses until everything has drained
    @(posedge clk);
    send_pause <= 1'b1;
    wait (expected_results.size() == 0);
    @(posedge clk);
    send_pause <= 1'b0;
    wait (pending_reqs.size() < 300);
    @(posedge clk);
    no_idling <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("extended_gcd_modular_inverse_top regression: pass");
    end else begin
      $display("extended_gcd_modular_inverse_top regression: fail");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(solve_request(
          make_req(req_type, operand_a, operand_b, modulus)));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (send_pause || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= r.mode;
          operand_a <= r.a;
          operand_b <= r.b;
          modulus <= r.m;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat, gcd %0d", gcd_value);
        end else begin
          egcd_result_t e;
          e = expected_results.pop_front();
          if (gcd_value !== e.g || coef_x !== e.x || coef_y !== e.y ||
              answer !== e.ans || status !== e.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp g=%0d x=%0d y=%0d ans=%0d st=%0d",
                        " got g=%0d x=%0d y=%0d ans=%0d st=%0d"},
                       e.g, $signed(e.x), $signed(e.y), e.ans, e.st,
                       gcd_value, coef_x, coef_y, answer, status);
          end
        end
      end
      if (recv_holdoff > 0) begin
        recv_holdoff <= recv_holdoff - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 3) == 0) begin
        recv_gap <= $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("extended_gcd_modular_inverse_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

### files.f
+incdir+design
design/egcd_pkg.sv
design/egcd_div.sv
design/egcd_dp.sv
design/egcd_ctrl.sv
design/extended_gcd_modular_inverse_top.sv
verif/extended_gcd_modular_inverse_top_tb.sv
